// ----- design/pau_pkg.sv -----
`timescale 1ns / 1ps

package pau_pkg;

    localparam int ACT_W = 2;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_OFFER = 2'd0;
    localparam t_action ACT_CLEAR = 2'd1;
    localparam t_action ACT_READ  = 2'd2;

    // control part of the wave that walks the cell row
    typedef struct packed {
        logic    live;
        t_action action;
        logic    beaten;
        logic    free_found;
        logic    rd_valid;
    } t_wave_ctl;

endpackage

// ----- design/pau_in_if.sv -----
`timescale 1ns / 1ps

interface pau_in_if #(
    parameter int COST_W = 16,
    parameter int SLOT_W = 6
) ();
    logic                   valid;
    logic                   ready;
    logic [pau_pkg::ACT_W-1:0] action;
    logic [COST_W-1:0]      first_cost;
    logic [COST_W-1:0]      second_cost;
    logic [SLOT_W-1:0]      slot;

    modport source (
        output valid, action, first_cost, second_cost, slot,
        input  ready
    );
    modport sink (
        input  valid, action, first_cost, second_cost, slot,
        output ready
    );
endinterface

// ----- design/pau_out_if.sv -----
`timescale 1ns / 1ps

interface pau_out_if #(
    parameter int COST_W  = 16,
    parameter int COUNT_W = 7
) ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] occupancy;
    logic               overflow;
    logic               read_valid;
    logic [COST_W-1:0]  read_first;
    logic [COST_W-1:0]  read_second;

    modport source (
        output valid, accepted, removed_count, occupancy, overflow,
               read_valid, read_first, read_second,
        input  ready
    );
    modport sink (
        input  valid, accepted, removed_count, occupancy, overflow,
               read_valid, read_first, read_second,
        output ready
    );
endinterface

// ----- design/pau_cell.sv -----
`timescale 1ns / 1ps

module pau_cell #(
    parameter int IDX     = 0,
    parameter int COST_W  = 16,
    parameter int SLOT_W  = 6,
    parameter int COUNT_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [COST_W-1:0]   i_first_cost,
    input  logic [COST_W-1:0]   i_second_cost,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_commit,
    input  pau_pkg::t_wave_ctl  i_ctl,
    input  logic [COUNT_W-1:0]  i_removed,
    input  logic [COUNT_W-1:0]  i_occ,
    input  logic [COST_W-1:0]   i_rd_first,
    input  logic [COST_W-1:0]   i_rd_second,
    output pau_pkg::t_wave_ctl  o_ctl,
    output logic [COUNT_W-1:0]  o_removed,
    output logic [COUNT_W-1:0]  o_occ,
    output logic [COST_W-1:0]   o_rd_first,
    output logic [COST_W-1:0]   o_rd_second
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    function automatic logic dominates(
        input logic [COST_W-1:0] a1,
        input logic [COST_W-1:0] a2,
        input logic [COST_W-1:0] b1,
        input logic [COST_W-1:0] b2
    );
        return (a1 <= b1) && (a2 <= b2) && ((a1 < b1) || (a2 < b2));
    endfunction

    logic               r_valid;
    logic               r_pend;
    logic [COST_W-1:0]  r_first;
    logic [COST_W-1:0]  r_second;

    pau_pkg::t_wave_ctl r_o_ctl;
    logic [COUNT_W-1:0] r_o_removed;
    logic [COUNT_W-1:0] r_o_occ;
    logic [COST_W-1:0]  r_o_rd_first;
    logic [COST_W-1:0]  r_o_rd_second;

    logic               is_off;
    logic               is_clr;
    logic               is_rd;
    logic               kill;
    logic               keep;
    logic               hit;
    logic               free_here;
    pau_pkg::t_wave_ctl n_ctl;

    always_comb begin
        is_off    = (i_ctl.action == pau_pkg::ACT_OFFER);
        is_clr    = (i_ctl.action == pau_pkg::ACT_CLEAR);
        is_rd     = (i_ctl.action == pau_pkg::ACT_READ);
        kill      = r_valid && is_off && dominates(i_first_cost, i_second_cost, r_first, r_second);
        keep      = r_valid && !kill && !is_clr;
        hit       = r_valid && is_rd && (i_slot == MY_SLOT);
        free_here = is_off && !keep;

        n_ctl            = i_ctl;
        n_ctl.beaten     = i_ctl.beaten
                         | (is_off && keep
                            && dominates(r_first, r_second, i_first_cost, i_second_cost));
        n_ctl.free_found = i_ctl.free_found | free_here;
        n_ctl.rd_valid   = i_ctl.rd_valid | hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_o_ctl <= '0;
        end else begin
            r_o_ctl <= i_ctl.live ? n_ctl : '0;
            if (i_ctl.live) begin
                r_valid <= keep;
                // lowest free slot claims the point; it goes valid on commit
                r_pend  <= free_here && !i_ctl.free_found;
            end else if (i_commit) begin
                if (r_pend) begin
                    r_valid <= 1'b1;
                end
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_removed   <= i_removed + COUNT_W'(kill);
        r_o_occ       <= i_occ + COUNT_W'(keep);
        r_o_rd_first  <= hit ? r_first  : i_rd_first;
        r_o_rd_second <= hit ? r_second : i_rd_second;
        if (i_commit && r_pend) begin
            r_first  <= i_first_cost;
            r_second <= i_second_cost;
        end
    end

    assign o_ctl       = r_o_ctl;
    assign o_removed   = r_o_removed;
    assign o_occ       = r_o_occ;
    assign o_rd_first  = r_o_rd_first;
    assign o_rd_second = r_o_rd_second;

endmodule

// ----- design/pareto_archive_update_core.sv -----
`timescale 1ns / 1ps

// Two-objective Pareto archive of ARCHIVE_DEPTH slots held in a row of cells.
// Every word (offer, clear, read) launches a wave that visits one cell per
// cycle: on an offer each cell drops its entry if the offered point dominates
// it, flags the point as beaten if its entry dominates the point, marks the
// lowest free slot and passes running removed and occupancy counts on; a clear
// empties every cell and a read returns the addressed slot. At the end of the
// row an unbeaten point is committed to the marked slot if one was found. One
// word is in flight at a time; a finished result waits in the output register
// while the next word is accepted. Costs compare as plain unsigned integers;
// reads of a slot beyond the depth return an empty slot.
module pareto_archive_update_core #(
    parameter int ARCHIVE_DEPTH = 64,
    parameter int COST_WIDTH    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pau_in_if.sink     i_in,
    pau_out_if.source  o_out
);

    localparam int SLOT_W  = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(ARCHIVE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state;
    pau_pkg::t_wave_ctl  r_launch;
    logic [COST_WIDTH-1:0] r_c1;
    logic [COST_WIDTH-1:0] r_c2;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_commit;

    pau_pkg::t_wave_ctl  r_fin_ctl;
    logic [COUNT_W-1:0]  r_fin_rem;
    logic [COUNT_W-1:0]  r_fin_occ;
    logic [COST_WIDTH-1:0] r_fin_rf;
    logic [COST_WIDTH-1:0] r_fin_rs;

    logic                r_out_valid;
    logic                r_out_accepted;
    logic [COUNT_W-1:0]  r_out_removed;
    logic [COUNT_W-1:0]  r_out_occ;
    logic                r_out_overflow;
    logic                r_out_rd_valid;
    logic [COST_WIDTH-1:0] r_out_rf;
    logic [COST_WIDTH-1:0] r_out_rs;

    pau_pkg::t_wave_ctl  ctl_w [ARCHIVE_DEPTH+1];
    logic [COUNT_W-1:0]  rem_w [ARCHIVE_DEPTH+1];
    logic [COUNT_W-1:0]  occ_w [ARCHIVE_DEPTH+1];
    logic [COST_WIDTH-1:0] rf_w [ARCHIVE_DEPTH+1];
    logic [COST_WIDTH-1:0] rs_w [ARCHIVE_DEPTH+1];

    logic in_acc;
    logic fin_offer;
    logic fin_commit;
    logic fin_overflow;
    logic out_free;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    assign fin_offer    = (r_fin_ctl.action == pau_pkg::ACT_OFFER);
    assign fin_commit   = fin_offer && !r_fin_ctl.beaten && r_fin_ctl.free_found;
    assign fin_overflow = fin_offer && !r_fin_ctl.beaten && !r_fin_ctl.free_found;

    assign ctl_w[0] = r_launch;
    assign rem_w[0] = '0;
    assign occ_w[0] = '0;
    assign rf_w[0]  = '0;
    assign rs_w[0]  = '0;

    for (genvar g = 0; g < ARCHIVE_DEPTH; g++) begin : g_cell
        pau_cell #(
            .IDX     (g),
            .COST_W  (COST_WIDTH),
            .SLOT_W  (SLOT_W),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_first_cost  (r_c1),
            .i_second_cost (r_c2),
            .i_slot        (r_slot),
            .i_commit      (r_commit),
            .i_ctl         (ctl_w[g]),
            .i_removed     (rem_w[g]),
            .i_occ         (occ_w[g]),
            .i_rd_first    (rf_w[g]),
            .i_rd_second   (rs_w[g]),
            .o_ctl         (ctl_w[g+1]),
            .o_removed     (rem_w[g+1]),
            .o_occ         (occ_w[g+1]),
            .o_rd_first    (rf_w[g+1]),
            .o_rd_second   (rs_w[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= '0;
            r_commit    <= 1'b0;
            r_fin_ctl   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= '0;
            r_commit <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_launch.live   <= 1'b1;
                        r_launch.action <= i_in.action;
                        r_state         <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (ctl_w[ARCHIVE_DEPTH].live) begin
                        r_fin_ctl <= ctl_w[ARCHIVE_DEPTH];
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_commit    <= fin_commit;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_c1   <= i_in.first_cost;
            r_c2   <= i_in.second_cost;
            r_slot <= i_in.slot;
        end
        if (r_state == S_RUN && ctl_w[ARCHIVE_DEPTH].live) begin
            r_fin_rem <= rem_w[ARCHIVE_DEPTH];
            r_fin_occ <= occ_w[ARCHIVE_DEPTH];
            r_fin_rf  <= rf_w[ARCHIVE_DEPTH];
            r_fin_rs  <= rs_w[ARCHIVE_DEPTH];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_accepted <= fin_commit;
            r_out_removed  <= r_fin_rem;
            // the claimed slot turns valid at commit, after the wave counted it free
            r_out_occ      <= r_fin_occ + COUNT_W'(fin_commit);
            r_out_overflow <= fin_overflow;
            r_out_rd_valid <= r_fin_ctl.rd_valid;
            r_out_rf       <= r_fin_rf;
            r_out_rs       <= r_fin_rs;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out_accepted;
    assign o_out.removed_count = r_out_removed;
    assign o_out.occupancy     = r_out_occ;
    assign o_out.overflow      = r_out_overflow;
    assign o_out.read_valid    = r_out_rd_valid;
    assign o_out.read_first    = r_out_rf;
    assign o_out.read_second   = r_out_rs;

endmodule

// ----- design/pau_checker.sv -----
`timescale 1ns / 1ps

module pau_checker #(
    parameter int ARCHIVE_DEPTH = 64,
    parameter int COUNT_W       = 7
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_accepted,
    input logic [COUNT_W-1:0] i_removed_count,
    input logic [COUNT_W-1:0] i_occupancy,
    input logic               i_overflow,
    input logic               i_read_valid
);

    localparam logic [COUNT_W-1:0] MAX_OCC = COUNT_W'(ARCHIVE_DEPTH);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word accepted while one is in flight");

    a_acc_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_accepted && i_overflow))
        else $error("offer reported both inserted and overflowed");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_read_valid |->
            !i_accepted && !i_overflow && (i_removed_count == '0))
        else $error("read result carries offer fields");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_occupancy <= MAX_OCC)
                        && (i_removed_count <= MAX_OCC))
        else $error("count beyond archive depth");

endmodule

bind pareto_archive_update_core pau_checker #(
    .ARCHIVE_DEPTH (ARCHIVE_DEPTH),
    .COUNT_W       ($clog2(ARCHIVE_DEPTH + 1))
) u_pau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_accepted      (o_out.accepted),
    .i_removed_count (o_out.removed_count),
    .i_occupancy     (o_out.occupancy),
    .i_overflow      (o_out.overflow),
    .i_read_valid    (o_out.read_valid)
);
